/* hdl/tps_pkg.sv */
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, constants and the sine duty lookup for the three-phase
// sine stepper.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int TABLE_STEPS = 128;
    localparam int TABLE_DEN   = 3 * TABLE_STEPS;
    localparam int QUARTER     = TABLE_DEN / 4;
    localparam int PHASE_W     = 7;
    localparam int POS_W       = 16;
    localparam int DUTY_W      = 8;
    localparam int IDX_W       = 9;
    localparam int MAG_W       = 7;

    localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(TABLE_STEPS - 1);
    localparam logic [DUTY_W-1:0]  DUTY_MID    = 8'd128;
    localparam logic [DUTY_W-1:0]  DUTY_MIN    = 8'd8;
    localparam logic [DUTY_W-1:0]  DUTY_MAX    = 8'd248;
    localparam logic signed [POS_W-1:0] HOME_TARGET = -16'sd32000;

    // Phase offsets, in table units, of the B and C windings.
    localparam logic [IDX_W:0] OFFSET_B = 10'(2 * TABLE_STEPS);
    localparam logic [IDX_W:0] OFFSET_C = 10'(TABLE_STEPS);
    localparam logic [IDX_W:0] DEN_W    = 10'(TABLE_DEN);

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_MOVE_ABS   = 3'd1,
        OP_MOVE_REL   = 3'd2,
        OP_ZERO_POS   = 3'd3,
        OP_HOME       = 3'd4,
        OP_SET_MOVING = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_UP   = 2'b01,
        DIR_DOWN = 2'b10
    } dir_t;

    // Status of the stepper after one command, handed to the lookup stage.
    typedef struct packed {
        logic [PHASE_W-1:0]      phase;
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] target;
        logic                    moving;
    } status_t;

    // round(120 * sin(2*pi*k/384)) for the first quarter turn, k = 0..96.
    function automatic logic [MAG_W-1:0] quarter_mag(logic [MAG_W-1:0] k);
        logic [MAG_W-1:0] m;
        case (k)
            7'd0: m = 7'd0;     7'd1: m = 7'd2;     7'd2: m = 7'd4;     7'd3: m = 7'd6;
            7'd4: m = 7'd8;     7'd5: m = 7'd10;    7'd6: m = 7'd12;    7'd7: m = 7'd14;
            7'd8: m = 7'd16;    7'd9: m = 7'd18;    7'd10: m = 7'd20;   7'd11: m = 7'd21;
            7'd12: m = 7'd23;   7'd13: m = 7'd25;   7'd14: m = 7'd27;   7'd15: m = 7'd29;
            7'd16: m = 7'd31;   7'd17: m = 7'd33;   7'd18: m = 7'd35;   7'd19: m = 7'd37;
            7'd20: m = 7'd39;   7'd21: m = 7'd40;   7'd22: m = 7'd42;   7'd23: m = 7'd44;
            7'd24: m = 7'd46;   7'd25: m = 7'd48;   7'd26: m = 7'd50;   7'd27: m = 7'd51;
            7'd28: m = 7'd53;   7'd29: m = 7'd55;   7'd30: m = 7'd57;   7'd31: m = 7'd58;
            7'd32: m = 7'd60;   7'd33: m = 7'd62;   7'd34: m = 7'd63;   7'd35: m = 7'd65;
            7'd36: m = 7'd67;   7'd37: m = 7'd68;   7'd38: m = 7'd70;   7'd39: m = 7'd71;
            7'd40: m = 7'd73;   7'd41: m = 7'd75;   7'd42: m = 7'd76;   7'd43: m = 7'd78;
            7'd44: m = 7'd79;   7'd45: m = 7'd81;   7'd46: m = 7'd82;   7'd47: m = 7'd83;
            7'd48: m = 7'd85;   7'd49: m = 7'd86;   7'd50: m = 7'd88;   7'd51: m = 7'd89;
            7'd52: m = 7'd90;   7'd53: m = 7'd92;   7'd54: m = 7'd93;   7'd55: m = 7'd94;
            7'd56: m = 7'd95;   7'd57: m = 7'd96;   7'd58: m = 7'd98;   7'd59: m = 7'd99;
            7'd60: m = 7'd100;  7'd61: m = 7'd101;  7'd62: m = 7'd102;  7'd63: m = 7'd103;
            7'd64: m = 7'd104;  7'd65: m = 7'd105;  7'd66: m = 7'd106;  7'd67: m = 7'd107;
            7'd68: m = 7'd108;  7'd69: m = 7'd108;  7'd70: m = 7'd109;  7'd71: m = 7'd110;
            7'd72: m = 7'd111;  7'd73: m = 7'd112;  7'd74: m = 7'd112;  7'd75: m = 7'd113;
            7'd76: m = 7'd114;  7'd77: m = 7'd114;  7'd78: m = 7'd115;  7'd79: m = 7'd115;
            7'd80: m = 7'd116;  7'd81: m = 7'd116;  7'd82: m = 7'd117;  7'd83: m = 7'd117;
            7'd84: m = 7'd118;  7'd85: m = 7'd118;  7'd86: m = 7'd118;  7'd87: m = 7'd119;
            7'd88: m = 7'd119;  7'd89: m = 7'd119;  7'd90: m = 7'd119;  7'd91: m = 7'd120;
            7'd92: m = 7'd120;  7'd93: m = 7'd120;  7'd94: m = 7'd120;  7'd95: m = 7'd120;
            7'd96: m = 7'd120;
            default: m = 7'd0;
        endcase
        return m;
    endfunction

    // round(128 + 120 * sin(2*pi*n/384)) for n = 0..383, folded onto the
    // first quarter turn.
    function automatic logic [DUTY_W-1:0] sine_duty(logic [IDX_W-1:0] n);
        logic [IDX_W-1:0] k;
        logic             neg;
        logic [MAG_W-1:0] mag;
        if (n < IDX_W'(QUARTER)) begin
            k   = n;
            neg = 1'b0;
        end
        else if (n < IDX_W'(2 * QUARTER)) begin
            k   = IDX_W'(2 * QUARTER) - n;
            neg = 1'b0;
        end
        else if (n < IDX_W'(3 * QUARTER)) begin
            k   = n - IDX_W'(2 * QUARTER);
            neg = 1'b1;
        end
        else begin
            k   = IDX_W'(TABLE_DEN) - n;
            neg = 1'b1;
        end
        mag = quarter_mag(k[MAG_W-1:0]);
        return neg ? (DUTY_MID - {1'b0, mag}) : (DUTY_MID + {1'b0, mag});
    endfunction

endpackage

/* hdl/tps_update.sv */
// ----------------------------------------------------------------------------
// tps_update
// Command decoder and motion state: phase, position, target, direction and
// moving flag, with a registered status word toward the lookup stage.
// ----------------------------------------------------------------------------
module tps_update
    import tps_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              opcode,
    input  logic signed [POS_W-1:0] value,
    output logic                    s1_valid,
    input  logic                    s1_ready,
    output status_t                 s1_status
);

    logic [PHASE_W-1:0]      phase_reg,  phase_next;
    logic signed [POS_W-1:0] pos_reg,    pos_next;
    logic signed [POS_W-1:0] tgt_reg,    tgt_next;
    dir_t                    dir_reg,    dir_next;
    logic                    move_reg,   move_next;
    logic                    s1_valid_reg;
    status_t                 s1_status_reg;

    logic                    accept;
    logic                    start_en;
    logic signed [POS_W-1:0] start_base;
    logic signed [POS_W-1:0] start_tgt;

    assign in_ready  = !s1_valid_reg || s1_ready;
    assign accept    = in_valid && in_ready;
    assign s1_valid  = s1_valid_reg;
    assign s1_status = s1_status_reg;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        tgt_next   = tgt_reg;
        dir_next   = dir_reg;
        move_next  = move_reg;
        start_en   = 1'b0;
        start_base = pos_reg;
        start_tgt  = value;

        case (opcode_t'(opcode))
            OP_TICK:
            begin
                if (move_reg && dir_reg != DIR_NONE) begin
                    if (dir_reg == DIR_UP) begin
                        phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
                        pos_next   = pos_reg + 16'sd1;
                    end
                    else begin
                        phase_next = (phase_reg == '0) ? PHASE_LAST : phase_reg - 1'b1;
                        pos_next   = pos_reg - 16'sd1;
                    end
                    if (pos_next == tgt_reg) begin
                        move_next = 1'b0;
                        dir_next  = DIR_NONE;
                    end
                end
            end
            OP_MOVE_ABS:
            begin
                start_en = 1'b1;
            end
            OP_MOVE_REL:
            begin
                start_en  = 1'b1;
                start_tgt = pos_reg + value;
            end
            OP_ZERO_POS:
            begin
                pos_next = '0;
            end
            OP_HOME:
            begin
                pos_next   = '0;
                start_en   = 1'b1;
                start_base = '0;
                start_tgt  = HOME_TARGET;
            end
            OP_SET_MOVING:
            begin
                move_next = value[0];
            end
            default:
            begin
                move_next = move_reg;
            end
        endcase

        // A new target picks its direction from a signed compare against
        // the position it starts from.
        if (start_en) begin
            tgt_next  = start_tgt;
            move_next = (start_tgt != start_base);
            if (start_tgt > start_base) begin
                dir_next = DIR_UP;
            end
            else if (start_tgt < start_base) begin
                dir_next = DIR_DOWN;
            end
            else begin
                dir_next = DIR_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg    <= '0;
            pos_reg      <= '0;
            tgt_reg      <= '0;
            dir_reg      <= DIR_NONE;
            move_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else begin
            if (accept) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                tgt_reg   <= tgt_next;
                dir_reg   <= dir_next;
                move_reg  <= move_next;
            end
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_status_reg.phase    <= phase_next;
            s1_status_reg.position <= pos_next;
            s1_status_reg.target   <= tgt_next;
            s1_status_reg.moving   <= move_next;
        end
    end

`ifndef SYNTHESIS
    a_tick_up_advances: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode == OP_TICK && move_reg && dir_reg == DIR_UP
        |=> phase_reg == PHASE_W'($past(phase_reg) + 1'b1))
        else $error("upward tick did not advance the phase");

    a_stopped_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode == OP_TICK && !move_reg
        |=> $stable(pos_reg) && $stable(phase_reg))
        else $error("tick while stopped changed the position or phase");

    a_move_abs_target: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode == OP_MOVE_ABS
        |=> tgt_reg == $past(value) && move_reg == (tgt_reg != pos_reg))
        else $error("absolute move did not load the target");
`endif

endmodule

/* hdl/tps_commutate.sv */
// ----------------------------------------------------------------------------
// tps_commutate
// Sine table lookup for the three windings and the result register.
// ----------------------------------------------------------------------------
module tps_commutate
    import tps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s1_valid,
    output logic                      s1_ready,
    input  status_t                   s1_status,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [DUTY_W-1:0]         duty_a,
    output logic [DUTY_W-1:0]         duty_b,
    output logic [DUTY_W-1:0]         duty_c,
    output logic [PHASE_W-1:0]        phase_index,
    output logic signed [POS_W-1:0]   cur_position,
    output logic signed [POS_W-1:0]   cur_target,
    output logic                      is_moving
);

    logic                    out_valid_reg;
    logic [DUTY_W-1:0]       duty_a_reg, duty_b_reg, duty_c_reg;
    status_t                 status_reg;

    logic [IDX_W:0]          idx_a, sum_b, sum_c;
    logic [IDX_W-1:0]        idx_b, idx_c;

    // Table position is three times the phase; B and C sit a third and two
    // thirds of a turn behind, taken modulo the table length.
    assign idx_a = ({3'b000, s1_status.phase} << 1) + {3'b000, s1_status.phase};
    assign sum_b = idx_a + OFFSET_B;
    assign sum_c = idx_a + OFFSET_C;
    assign idx_b = (sum_b >= DEN_W) ? IDX_W'(sum_b - DEN_W) : sum_b[IDX_W-1:0];
    assign idx_c = (sum_c >= DEN_W) ? IDX_W'(sum_c - DEN_W) : sum_c[IDX_W-1:0];

    assign s1_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_ready) begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid && s1_ready) begin
            duty_a_reg <= sine_duty(idx_a[IDX_W-1:0]);
            duty_b_reg <= sine_duty(idx_b);
            duty_c_reg <= sine_duty(idx_c);
            status_reg <= s1_status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign duty_a       = duty_a_reg;
    assign duty_b       = duty_b_reg;
    assign duty_c       = duty_c_reg;
    assign phase_index  = status_reg.phase;
    assign cur_position = status_reg.position;
    assign cur_target   = status_reg.target;
    assign is_moving    = status_reg.moving;

`ifndef SYNTHESIS
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> duty_a_reg >= DUTY_MIN && duty_a_reg <= DUTY_MAX
            && duty_b_reg >= DUTY_MIN && duty_b_reg <= DUTY_MAX
            && duty_c_reg >= DUTY_MIN && duty_c_reg <= DUTY_MAX)
        else $error("duty value outside the sine swing");

    a_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg.phase == '0
        |-> duty_a_reg == DUTY_MID && ({1'b0, duty_b_reg} + {1'b0, duty_c_reg}) == 9'd256)
        else $error("phase zero duties are not balanced about midscale");
`endif

endmodule

/* hdl/three_phase_sine_stepper_top.sv */
// ----------------------------------------------------------------------------
// three_phase_sine_stepper_top
// Throughput: one command per cycle unless the output stalls, one result
// word per command; the command decoder and the sine table stage each
// hold one register, and a command's word passes them in that order.
// Reset (rst_n, asynchronous): phase, position, target, direction and the
// moving flag clear to zero; both pipeline stages empty.
// ----------------------------------------------------------------------------
module three_phase_sine_stepper_top
    import tps_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              opcode,
    input  logic signed [POS_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [DUTY_W-1:0]       duty_a,
    output logic [DUTY_W-1:0]       duty_b,
    output logic [DUTY_W-1:0]       duty_c,
    output logic [PHASE_W-1:0]      phase_index,
    output logic signed [POS_W-1:0] cur_position,
    output logic signed [POS_W-1:0] cur_target,
    output logic                    is_moving
);

    // The update stage owns the motion state. Every accepted command word
    // updates it and pushes a snapshot of the new status into its stage
    // register, so the next command may follow immediately unless that register is held by a stall.
    logic    s1_valid;
    logic    s1_ready;
    status_t s1_status;

    tps_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .value     (value),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .s1_status (s1_status)
    );

    // The commutation stage turns the snapshot's phase into three duty
    // values from the folded sine table and holds the finished result word.
    // While that word waits for the consumer, the update stage can still
    // take one more command if its own register is empty. Once both
    // registers hold words, a stall at the output stops input in the same
    // cycle.
    tps_commutate u_commutate (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1_ready     (s1_ready),
        .s1_status    (s1_status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .duty_a       (duty_a),
        .duty_b       (duty_b),
        .duty_c       (duty_c),
        .phase_index  (phase_index),
        .cur_position (cur_position),
        .cur_target   (cur_target),
        .is_moving    (is_moving)
    );

endmodule

/* dv/three_phase_sine_stepper_top_test.sv */
// ----------------------------------------------------------------------------
// three_phase_sine_stepper_top_test
// Self-checking bench for the three-phase sine stepper. Command words are
// mirrored into a behavioral model of the stepper state and the sine
// table, and every result word is compared field by field against the
// oldest outstanding prediction, under random idling on both handshakes.
// ----------------------------------------------------------------------------
module three_phase_sine_stepper_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tps_pkg::*;

    // Opcodes six and seven are not decoded by the block. They must still
    // produce a status word with no change of state.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Length of the deliberate output stall, and the number of cycles with
    // no handshake on either side after which the run is declared hung.
    localparam int HOLD_CYCLES  = 90;
    localparam int HANG_LIMIT   = 4000;
    localparam int SETTLE_TICKS = 8;

    // One predicted status word, as the block should present it.
    typedef struct {
        logic [DUTY_W-1:0]       duty_a;
        logic [DUTY_W-1:0]       duty_b;
        logic [DUTY_W-1:0]       duty_c;
        logic [PHASE_W-1:0]      phase;
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] target;
        logic                    moving;
    } step_status_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a behavioral copy of the stepper plus the queue of status
    // words that the block still owes.
    // ------------------------------------------------------------------------
    class stepper_scoreboard;
        logic [DUTY_W-1:0]       sine_table[TABLE_DEN];
        logic [PHASE_W-1:0]      phase;
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] target;
        dir_t                    heading;
        logic                    moving;
        step_status_t            owed[$];
        int                      op_seen[8];
        int                      accepted;
        int                      results_checked;
        int                      moves_done;
        int                      wraps;
        int                      fails;

        function new();
            real angle;
            // Full turn of 128 + 120*sin sampled at 384 points. Winding A
            // uses every third entry; B and C are offset by two thirds and a third of a turn.
            for (int n = 0; n < TABLE_DEN; n++)
            begin
                angle = 6.283185307179586 * n / TABLE_DEN;
                sine_table[n] = DUTY_W'(128 + $rtoi($floor(120.0 * $sin(angle) + 0.5)));
            end
            phase           = '0;
            position        = '0;
            target          = '0;
            heading         = DIR_NONE;
            moving          = 1'b0;
            accepted        = 0;
            results_checked = 0;
            moves_done      = 0;
            wraps           = 0;
            fails           = 0;
        endfunction

        // New target: direction follows the signed comparison with the
        // current position, and an equal target leaves the motor stopped.
        function void aim_at(logic signed [POS_W-1:0] goal);
            target = goal;
            if (goal > position)
                heading = DIR_UP;
            else if (goal < position)
                heading = DIR_DOWN;
            else
                heading = DIR_NONE;
            moving = (heading != DIR_NONE);
        endfunction

        function void note_command(logic [2:0] op, logic signed [POS_W-1:0] val);
            step_status_t s;
            int           base;
            case (op)
                OP_TICK:
                begin
                    if (moving && heading != DIR_NONE)
                    begin
                        if (heading == DIR_UP)
                        begin
                            phase = (phase == PHASE_LAST) ? '0 : phase + 1'b1;
                            if (position == 16'sh7FFF)
                                wraps++;
                            position = position + 16'sd1;
                        end
                        else
                        begin
                            phase = (phase == '0) ? PHASE_LAST : phase - 1'b1;
                            if (position == 16'sh8000)
                                wraps++;
                            position = position - 16'sd1;
                        end
                        if (position == target)
                        begin
                            moving  = 1'b0;
                            heading = DIR_NONE;
                            moves_done++;
                        end
                    end
                end
                OP_MOVE_ABS:   aim_at(val);
                OP_MOVE_REL:   aim_at(position + val);
                OP_ZERO_POS:   position = '0;
                OP_HOME:
                begin
                    position = '0;
                    aim_at(HOME_TARGET);
                end
                OP_SET_MOVING: moving = val[0];
                default:       ;
            endcase
            base       = 3 * int'(phase);
            s.duty_a   = sine_table[base];
            s.duty_b   = sine_table[(base + 2 * TABLE_STEPS) % TABLE_DEN];
            s.duty_c   = sine_table[(base + TABLE_STEPS) % TABLE_DEN];
            s.phase    = phase;
            s.position = position;
            s.target   = target;
            s.moving   = moving;
            owed.push_back(s);
            op_seen[op]++;
            accepted++;
        endfunction

        function void compare_field(string field, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                fails++;
            end
        endfunction

        function void check_result(logic [DUTY_W-1:0] da, logic [DUTY_W-1:0] db,
                                   logic [DUTY_W-1:0] dc, logic [PHASE_W-1:0] ph,
                                   logic signed [POS_W-1:0] pos,
                                   logic signed [POS_W-1:0] tgt, logic mv);
            step_status_t s;
            results_checked++;
            if (owed.size() == 0)
            begin
                $error("status word arrived with no command waiting for it");
                fails++;
                return;
            end
            s = owed.pop_front();
            compare_field("duty_a", s.duty_a, da);
            compare_field("duty_b", s.duty_b, db);
            compare_field("duty_c", s.duty_c, dc);
            compare_field("phase_index", s.phase, ph);
            compare_field("cur_position", s.position, pos);
            compare_field("cur_target", s.target, tgt);
            compare_field("is_moving", s.moving, mv);
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [2:0]              opcode    = '0;
    logic signed [POS_W-1:0] value     = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [DUTY_W-1:0]       duty_a;
    logic [DUTY_W-1:0]       duty_b;
    logic [DUTY_W-1:0]       duty_c;
    logic [PHASE_W-1:0]      phase_index;
    logic signed [POS_W-1:0] cur_position;
    logic signed [POS_W-1:0] cur_target;
    logic                    is_moving;

    three_phase_sine_stepper_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .duty_a       (duty_a),
        .duty_b       (duty_b),
        .duty_c       (duty_c),
        .phase_index  (phase_index),
        .cur_position (cur_position),
        .cur_target   (cur_target),
        .is_moving    (is_moving)
    );

    stepper_scoreboard sb = new();

    // Percent of cycles in which each side idles. The main sequence changes
    // these between phases of the run.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // The main sequence raises this to ask the receiver for one long stall.
    // The receiver counts the stall itself and clears the request.
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int holds_done   = 0;
    int quiet_cycles = 0;

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Receiver. Outputs are sampled at the rising edge, before any of this
    // edge's updates land, and checked as soon as a word is taken. out_ready
    // is then chosen for the next cycle: a pending long stall wins, otherwise
    // it follows the current idle rate.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                sb.check_result(duty_a, duty_b, duty_c, phase_index,
                                cur_position, cur_target, is_moving);
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                holds_done++;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Hang detector: counts consecutive cycles in which no word moves on
    // either side. A stall longer than any legal one ends the run.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= HANG_LIMIT)
                begin
                    $display("no handshake for %0d cycles", HANG_LIMIT);
                    $display("three_phase_sine_stepper_top_test NOT OK");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Every task is entered right after a rising edge. A word is
    // presented with valid held high until the edge that takes it, and the
    // scoreboard learns of it at that same edge. Valid is only lowered for an
    // idle gap or a drain, so it never falls and rises within one step.
    // ------------------------------------------------------------------------
    task automatic send_word(logic [2:0] op, logic signed [POS_W-1:0] val);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_command(op, val);
    endtask

    // Stop offering words and wait until every status word owed has come.
    // At least one edge always passes, so valid cannot be raised again in
    // the step where it was lowered.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Ticks with random filler in the value field until the move ends or
    // the cap is hit.
    task automatic ticks_to_stop(int cap);
        int n;
        n = 0;
        while (sb.moving && n < cap)
        begin
            send_word(OP_TICK, 16'($urandom));
            n++;
        end
    endtask

    // A short well-formed move: aim a few counts away, either absolutely or
    // relatively, then tick it home. Pauses and position clears are mixed in
    // while it runs, and a few surplus ticks land on the stopped motor.
    task automatic short_move();
        int                      delta;
        int                      n;
        logic signed [POS_W-1:0] aim;
        delta = $urandom_range(24, 1);
        if ($urandom_range(1, 0))
            delta = -delta;
        aim = POS_W'(sb.position + delta);
        if ($urandom_range(1, 0))
            send_word(OP_MOVE_ABS, aim);
        else
            send_word(OP_MOVE_REL, POS_W'(delta));
        n = 0;
        while (sb.moving && n < 48)
        begin
            case ($urandom_range(19, 0))
                0:
                begin
                    send_word(OP_SET_MOVING, {15'($urandom), 1'b0});
                    send_word(OP_TICK, 16'($urandom));
                    send_word(OP_SET_MOVING, {15'($urandom), 1'b1});
                end
                1:       send_word(OP_ZERO_POS, 16'($urandom));
                default: send_word(OP_TICK, 16'($urandom));
            endcase
            n++;
        end
        repeat ($urandom_range(2, 0))
            send_word(OP_TICK, 16'($urandom));
    endtask

    // Roughly three quarters short moves, the rest any opcode with a fully
    // random value, which covers far targets, stray set_moving words and
    // the spare opcodes.
    task automatic random_traffic(int n_words);
        int goal;
        goal = sb.accepted + n_words;
        while (sb.accepted < goal)
        begin
            if ($urandom_range(99, 0) < 25)
                send_word(3'($urandom_range(7, 0)), 16'($urandom));
            else
                short_move();
        end
    endtask

    // Ask the receiver for a long stall and keep offering words back to back
    // so the pipeline fills and in_ready drops.
    task automatic flood_during_hold();
        int saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_request  = 1'b1;
        repeat (40)
            send_word(3'($urandom_range(7, 0)), 16'($urandom));
        send_idle_pct = saved_pct;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: sender idles now and then, receiver more than half the
        // time. Directed words come first, starting from the reset state.
        send_idle_pct = 17;
        recv_idle_pct = 56;

        // Ticks and set_moving with no direction must leave everything alone,
        // apart from the flag itself; an equal target stops the motor.
        send_word(OP_TICK, 16'h7FFF);
        send_word(OP_SET_MOVING, 16'h0001);
        send_word(OP_TICK, 16'h8000);
        send_word(OP_SET_MOVING, 16'hFFFE);
        send_word(OP_MOVE_ABS, 16'h0000);

        // A short move up to its target, then a tick after it has stopped.
        send_word(OP_MOVE_ABS, 16'sd3);
        ticks_to_stop(8);
        send_word(OP_TICK, 16'hFFFF);

        // Move down through phase zero, paused and resumed halfway.
        send_word(OP_MOVE_REL, -16'sd5);
        send_word(OP_TICK, 16'h0000);
        send_word(OP_TICK, 16'h5555);
        send_word(OP_SET_MOVING, 16'h0000);
        send_word(OP_TICK, 16'hAAAA);
        send_word(OP_SET_MOVING, 16'h0001);
        ticks_to_stop(8);

        // Largest positive offset, then clearing the position mid-move.
        send_word(OP_MOVE_REL, 16'sh7FFF);
        send_word(OP_TICK, 16'h0000);
        send_word(OP_ZERO_POS, 16'hFFFF);
        send_word(OP_TICK, 16'h0000);

        // Most negative absolute target, homing, and the spare opcodes.
        send_word(OP_MOVE_ABS, 16'sh8000);
        send_word(OP_TICK, 16'h0000);
        send_word(OP_HOME, 16'h0000);
        send_word(OP_TICK, 16'h0000);
        send_word(OP_SPARE_6, 16'h8000);
        send_word(OP_SPARE_7, 16'h7FFF);

        // A relative offset whose sum wraps, and the top absolute target.
        send_word(OP_MOVE_REL, 16'sh8000);
        send_word(OP_TICK, 16'h0000);
        send_word(OP_MOVE_ABS, 16'sh7FFF);
        send_word(OP_TICK, 16'h0000);
        drain();

        random_traffic(320);
        flood_during_hold();
        drain();

        // Phase two: the idle rates swap sides.
        send_idle_pct = 56;
        recv_idle_pct = 17;
        random_traffic(320);
        flood_during_hold();
        drain();

        // Phase three: no idling at all.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(320);

        // Homing from wherever the random traffic left off: a few steps down
        // toward the far target, then a short relative move back up that
        // ends the move.
        send_word(OP_HOME, 16'($urandom));
        repeat (12)
            send_word(OP_TICK, 16'($urandom));
        send_word(OP_MOVE_REL, 16'sd3);
        ticks_to_stop(8);
        drain();

        repeat (SETTLE_TICKS)
            @(posedge clk);

        $write("covered %0d commands: %0d tick, %0d abs, %0d rel, ",
               sb.accepted, sb.op_seen[OP_TICK], sb.op_seen[OP_MOVE_ABS],
               sb.op_seen[OP_MOVE_REL]);
        $display("%0d zero, %0d home, %0d flag, %0d spare",
                 sb.op_seen[OP_ZERO_POS], sb.op_seen[OP_HOME],
                 sb.op_seen[OP_SET_MOVING], sb.op_seen[OP_SPARE_6] + sb.op_seen[OP_SPARE_7]);
        $display("%0d words checked, %0d moves done, %0d wraps, %0d long stalls",
                 sb.results_checked, sb.moves_done, sb.wraps, holds_done);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("three_phase_sine_stepper_top_test OK");
        else
            $display("three_phase_sine_stepper_top_test NOT OK");
        $finish;
    end

endmodule

/* three_phase_sine_stepper_top.f */
hdl/tps_pkg.sv
hdl/tps_update.sv
hdl/tps_commutate.sv
hdl/three_phase_sine_stepper_top.sv
dv/three_phase_sine_stepper_top_test.sv
